>>> design/sldf_pkg.sv
`default_nettype none

package sldf_pkg;

  localparam logic [7:0]  SYNC_BYTE       = 8'hFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [8:0]  MAX_PAYLOAD_RST = 9'd256;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN,
    PH_PAYLOAD,
    PH_CRC_LO,
    PH_CRC_HI
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_GOOD,
    KIND_CRC_ERR,
    KIND_TOO_LONG
  } kind_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] data_byte;
    logic       is_last;
    logic [8:0] frame_length;
  } res_t;

  // CRC-16/MODBUS update over one byte, LSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> design/sldf_in_if.sv
`default_nettype none

interface sldf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> design/sldf_out_if.sv
`default_nettype none

interface sldf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic       is_last;
  logic [8:0] frame_length;

  modport source (output valid, output kind, output data_byte, output is_last,
                  output frame_length, input ready);
  modport sink (input valid, input kind, input data_byte, input is_last,
                input frame_length, output ready);
endinterface

`default_nettype wire

>>> design/sldf_frame_fsm.sv
`default_nettype none

module sldf_frame_fsm (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  input  wire logic [7:0]        rx_byte,
  input  wire logic [8:0]        max_payload,
  output sldf_pkg::res_t         res
);
  import sldf_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [8:0]  total_r, total_nxt;
  logic [8:0]  left_r, left_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic        skip_r, skip_nxt;

  logic [15:0] crc_upd;
  logic [8:0]  len_plus1;
  logic [8:0]  left_dec;

  assign crc_upd   = crc16_byte(crc_r, rx_byte);
  assign len_plus1 = {1'b0, rx_byte} + 9'd1;
  assign left_dec  = left_r - 9'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      crc_r    <= CRC_INIT;
      total_r  <= '0;
      left_r   <= '0;
      crc_lo_r <= '0;
      skip_r   <= 1'b0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      crc_r    <= crc_nxt;
      total_r  <= total_nxt;
      left_r   <= left_nxt;
      crc_lo_r <= crc_lo_nxt;
      skip_r   <= skip_nxt;
    end
  end

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    crc_nxt    = crc_r;
    total_nxt  = total_r;
    left_nxt   = left_r;
    crc_lo_nxt = crc_lo_r;
    skip_nxt   = skip_r;
    unique case (phase_r)
      PH_LEN: begin
        crc_nxt   = crc_upd;
        total_nxt = len_plus1;
        left_nxt  = len_plus1;
        skip_nxt  = (len_plus1 > max_payload);
        phase_nxt = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        crc_nxt  = crc_upd;
        left_nxt = left_dec;
        if (left_dec == 9'd0) begin
          phase_nxt = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        crc_lo_nxt = rx_byte;
        phase_nxt  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        phase_nxt = PH_HUNT;
        crc_nxt   = CRC_INIT;
        skip_nxt  = 1'b0;
        left_nxt  = '0;
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (rx_byte == SYNC_BYTE) begin
          crc_nxt   = crc16_byte(CRC_INIT, rx_byte);
          phase_nxt = PH_LEN;
        end
      end
    endcase
  end

  // result for the byte being processed
  always_comb begin
    res = '{valid: 1'b0, kind: KIND_DATA, data_byte: 8'h00, is_last: 1'b0,
            frame_length: 9'd0};
    unique case (phase_r)
      PH_PAYLOAD: begin
        if (!skip_r) begin
          res.valid     = 1'b1;
          res.data_byte = rx_byte;
        end
      end
      PH_CRC_HI: begin
        res.valid        = 1'b1;
        res.is_last      = 1'b1;
        res.frame_length = total_r;
        if (skip_r) begin
          res.kind = KIND_TOO_LONG;
        end else if ({rx_byte, crc_lo_r} == crc_r) begin
          res.kind = KIND_GOOD;
        end else begin
          res.kind = KIND_CRC_ERR;
        end
      end
      default: begin
        res.valid = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/sldf_out_reg.sv
`default_nettype none

module sldf_out_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  wire sldf_pkg::res_t  res,
  output logic                 busy,
  sldf_out_if.source           out_bus
);
  import sldf_pkg::*;

  logic       valid_r;
  kind_t      kind_r;
  logic [7:0] data_r;
  logic       last_r;
  logic [8:0] len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= res.valid;
    end else if (out_bus.ready) begin
      valid_r <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= res.kind;
      data_r <= res.data_byte;
      last_r <= res.is_last;
      len_r  <= res.frame_length;
    end
  end

  // hold while a result waits and the sink stalls
  assign busy                 = valid_r && !out_bus.ready;
  assign out_bus.valid        = valid_r;
  assign out_bus.kind         = kind_r;
  assign out_bus.data_byte    = data_r;
  assign out_bus.is_last      = last_r;
  assign out_bus.frame_length = len_r;

endmodule

`default_nettype wire

>>> design/sync_length_crc16_packet_deframer.sv
`default_nettype none

// Channel   Direction  Handshake     Payload
// in_bus    sink       valid/ready   rx_byte[7:0]
// out_bus   source     valid/ready   kind[1:0], data_byte[7:0], is_last, frame_length[8:0]
// cfg       write      cfg_we        cfg_data[8:0] -> max_payload
//
// One byte per cycle while the output does not stall. A byte sits in the input
// register, then the CRC-16 and frame-state logic writes the output register, which
// holds the result until it transfers out. Reset is synchronous; afterwards the block
// hunts for sync and max_payload is 256. A stalled output holds the input register
// and drops ready.

module sync_length_crc16_packet_deframer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [8:0] cfg_data,
  sldf_in_if.sink         in_bus,
  sldf_out_if.source      out_bus
);
  import sldf_pkg::*;

  logic [8:0] max_payload_r;
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       advance;
  logic       out_busy;
  res_t       res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      max_payload_r <= cfg_data;
    end
  end

  assign advance      = in_valid_r && !out_busy;
  assign in_bus.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      in_byte_r <= in_bus.rx_byte;
    end
  end

  sldf_frame_fsm u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .rx_byte     (in_byte_r),
    .max_payload (max_payload_r),
    .res         (res)
  );

  sldf_out_reg u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (advance),
    .res     (res),
    .busy    (out_busy),
    .out_bus (out_bus)
  );

endmodule

`default_nettype wire
